[design/ncc_pkg.sv]
// shared types and constants for the nearest center classifier
package ncc_pkg;

  localparam int MAX_CLASSES  = 16;
  localparam int MAX_DIMS     = 32;
  localparam int FEATURE_BITS = 16;

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int DIM_W  = $clog2(MAX_DIMS);
  localparam int NCLS_W = 5;
  localparam int DIST_W = 38;
  localparam int DIFF_W = FEATURE_BITS + 1;
  localparam int SQ_W   = 2 * FEATURE_BITS + 1;

  localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};
  localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = NCLS_W'(MAX_CLASSES);

  localparam logic CMD_CENTER  = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  typedef struct packed {
    logic                           cmd;
    logic [CLS_W-1:0]               center_index;
    logic [DIM_W-1:0]               dim_index;
    logic signed [FEATURE_BITS-1:0] value;
    logic                           last_element;
  } item_t;

  typedef struct packed {
    logic [CLS_W-1:0]  class_index;
    logic [DIST_W-1:0] best_distance;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic [CLS_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } best_t;

endpackage

[design/ncc_cell.sv]
// one class cell: center row, squared difference, running distance, min compare
module ncc_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ncc_pkg::CLS_W-1:0] idx,
  input  logic                     active,
  input  ncc_pkg::tok_t            tok_in,
  input  ncc_pkg::best_t           best_in,
  output ncc_pkg::tok_t            tok_out,
  output ncc_pkg::best_t           best_out
);

  logic [ncc_pkg::FEATURE_BITS-1:0] mem [0:ncc_pkg::MAX_DIMS-1];
  logic [ncc_pkg::FEATURE_BITS-1:0] rdata;

  logic signed [ncc_pkg::DIFF_W-1:0]   diff;
  logic signed [2*ncc_pkg::DIFF_W-1:0] prod;
  logic [ncc_pkg::SQ_W-1:0]            sq;
  logic                                s2_acc;
  logic                                s2_last;
  logic                                s3_last;
  logic [ncc_pkg::DIST_W-1:0]          acc;
  logic [ncc_pkg::DIST_W-1:0]          acc_next;
  logic [ncc_pkg::DIST_W-1:0]          base;
  logic [ncc_pkg::DIST_W:0]            sum;
  logic                                take_own;

  // center row store
  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.item.cmd == ncc_pkg::CMD_CENTER &&
        tok_in.item.center_index == idx) begin
      mem[tok_in.item.dim_index] <= tok_in.item.value;
    end
    rdata <= mem[tok_in.item.dim_index];
  end

  // token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.item <= tok_in.item;
  end

  assign diff = {tok_out.item.value[ncc_pkg::FEATURE_BITS-1], tok_out.item.value}
              - {rdata[ncc_pkg::FEATURE_BITS-1], rdata};
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_acc  <= 1'b0;
      s2_last <= 1'b0;
      s3_last <= 1'b0;
    end else begin
      s2_acc  <= tok_out.valid && tok_out.item.cmd == ncc_pkg::CMD_FEATURE;
      s2_last <= tok_out.valid && tok_out.item.cmd == ncc_pkg::CMD_FEATURE &&
                 tok_out.item.last_element;
      s3_last <= s2_last;
    end
    sq <= prod[ncc_pkg::SQ_W-1:0];
  end

  // running distance, cleared after the pixel compare
  always_comb begin
    base = s3_last ? '0 : acc;
    sum  = {1'b0, base} + {{(ncc_pkg::DIST_W + 1 - ncc_pkg::SQ_W){1'b0}}, sq};
    if (s2_acc && active) begin
      acc_next = sum[ncc_pkg::DIST_W] ? ncc_pkg::DIST_MAX : sum[ncc_pkg::DIST_W-1:0];
    end else begin
      acc_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  // min chain, strict less keeps the lowest index on ties
  assign take_own = active && (idx == '0 || acc < best_in.distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_out.valid <= 1'b0;
    end else begin
      best_out.valid <= s3_last;
    end
    if (take_own) begin
      best_out.idx      <= idx;
      best_out.distance <= acc;
    end else begin
      best_out.idx      <= best_in.idx;
      best_out.distance <= best_in.distance;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    best_out.valid |-> best_out.idx <= idx)
    else $error("winner index beyond cell");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s3_last && !s2_acc) |=> acc == '0)
    else $error("distance not cleared after pixel");

  a_own_dist: assert property (@(posedge clk) disable iff (rst)
    (best_out.valid && best_out.idx == idx) |-> best_out.distance == $past(acc))
    else $error("winner distance mismatch");

endmodule

[design/nearest_center_classifier_unit.sv]
// nearest center classifier top level: chain of class cells
// throughput: one transfer per cycle, busy stays low; the cell chain is fully pipelined
// the item walks one cell per cycle; each cell adds a 3-stage read, square, accumulate path
// reset: running distances clear, num_classes returns to 16, centers undefined until written
// the receiver cannot stall: done is high for exactly one cycle per result
module nearest_center_classifier_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ncc_pkg::item_t              item,
  input  logic                        cfg_we,
  input  logic [ncc_pkg::NCLS_W-1:0]  cfg_wdata,
  output logic                        done,
  output ncc_pkg::result_t            result
);

  ncc_pkg::tok_t  tok  [0:ncc_pkg::MAX_CLASSES];
  ncc_pkg::best_t best [0:ncc_pkg::MAX_CLASSES];

  logic [ncc_pkg::NCLS_W-1:0]      num_classes;
  logic [ncc_pkg::NCLS_W-1:0]      n_eff;
  logic [ncc_pkg::MAX_CLASSES-1:0] active;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= ncc_pkg::NUM_CLASSES_RST;
    end else if (cfg_we) begin
      num_classes <= cfg_wdata;
    end
  end

  always_comb begin
    if (num_classes == '0) begin
      n_eff = ncc_pkg::NCLS_W'(1);
    end else if (num_classes > ncc_pkg::NCLS_W'(ncc_pkg::MAX_CLASSES)) begin
      n_eff = ncc_pkg::NCLS_W'(ncc_pkg::MAX_CLASSES);
    end else begin
      n_eff = num_classes;
    end
  end

  // input transfer register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= start && !busy;
    end
    tok[0].item <= item;
  end

  assign best[0] = '0;

  for (genvar k = 0; k < ncc_pkg::MAX_CLASSES; k++) begin : g_cell
    assign active[k] = ncc_pkg::NCLS_W'(k) < n_eff;

    ncc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (ncc_pkg::CLS_W'(k)),
      .active   (active[k]),
      .tok_in   (tok[k]),
      .best_in  (best[k]),
      .tok_out  (tok[k+1]),
      .best_out (best[k+1])
    );
  end

  assign done                 = best[ncc_pkg::MAX_CLASSES].valid;
  assign result.class_index   = best[ncc_pkg::MAX_CLASSES].idx;
  assign result.best_distance = best[ncc_pkg::MAX_CLASSES].distance;

endmodule
